/* design/ipd_pkg.sv */
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared constants and helpers for the +IPD frame payload extractor.
// ----------------------------------------------------------------------------
package ipd_pkg;

  localparam int unsigned LEN_CHARS_MAX_DEF = 4;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 14;
  localparam int unsigned CHARS_W = 3;
  localparam int unsigned POS_W   = 3;

  localparam logic [POS_W-1:0]  PREFIX_LEN = 3'd6;
  localparam logic [LEN_W-1:0]  LEN_SAT    = 14'd16383;
  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  // expected header bytes: CR LF + I P D
  function automatic logic [BYTE_W-1:0] prefix_byte(input logic [POS_W-1:0] pos);
    logic [BYTE_W-1:0] b;
    case (pos)
      3'd0:    b = 8'h0D;
      3'd1:    b = 8'h0A;
      3'd2:    b = 8'h2B;
      3'd3:    b = 8'h49;
      3'd4:    b = 8'h50;
      3'd5:    b = 8'h44;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

/* design/ipd_if.sv */
// ----------------------------------------------------------------------------
// ipd_in_if / ipd_out_if
// Valid/ready channels carrying received bytes and extracted payload items.
// ----------------------------------------------------------------------------
interface ipd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       msg_start;

  modport source (output valid, output rx_byte, output msg_start, input ready);
  modport sink   (input valid, input rx_byte, input msg_start, output ready);
endinterface

interface ipd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;
  logic       frame_error;

  modport source (output valid, output payload_byte, output last_byte,
                  output frame_error, input ready);
  modport sink   (input valid, input payload_byte, input last_byte,
                  input frame_error, output ready);
endinterface

/* design/ipd_frame_payload_extractor.sv */
// ----------------------------------------------------------------------------
// ipd_frame_payload_extractor
// Parses "\r\n+IPD,<len>:" message headers and forwards the payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one received modem byte per item, with msg_start high on the
//   first byte of each message. tx carries at most one item per input item:
//   a payload byte (last_byte high on the final one) or a single error item
//   when the length text runs longer than LEN_CHARS_MAX characters.
//   Header, separator, length and trailing bytes produce no tx item.
//   A result is in the tx register on the clock after its byte is taken.
//   Throughput is one byte per cycle while tx is not stalled, set by the
//   single state update between the rx handshake and the tx output register.
//   rx.ready stays high while the tx register is empty or being drained, so
//   a stalled receiver holds one result and then backs up the rx side.
//   A msg_start byte aborts any frame in progress and restarts the header
//   match. Synchronous reset empties the tx register and returns the parser
//   to idle; bytes before the first msg_start are dropped.
// ----------------------------------------------------------------------------
module ipd_frame_payload_extractor #(
  parameter int unsigned LEN_CHARS_MAX = ipd_pkg::LEN_CHARS_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ipd_in_if.sink        rx,
  ipd_out_if.source     tx
);
  import ipd_pkg::*;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_PREFIX  = 3'd1;
  localparam logic [2:0] PH_SEP     = 3'd2;
  localparam logic [2:0] PH_LENGTH  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_IGNORE  = 3'd5;

  localparam logic [CHARS_W-1:0] CHARS_LIMIT = CHARS_W'(LEN_CHARS_MAX);

  logic [2:0]         phase,        phase_next;
  logic [POS_W-1:0]   prefix_pos,   prefix_pos_next;
  logic [LEN_W-1:0]   length_accum, length_accum_next;
  logic [CHARS_W-1:0] length_chars, length_chars_next;
  logic               digits_ended, digits_ended_next;
  logic [LEN_W-1:0]   bytes_left,   bytes_left_next;

  logic [2:0]         s_phase;
  logic [POS_W-1:0]   s_pos;
  logic [LEN_W-1:0]   s_accum;
  logic [CHARS_W-1:0] s_chars;
  logic               s_ended;
  logic [LEN_W-1:0]   s_left;

  logic               res_valid;
  logic [BYTE_W-1:0]  res_byte;
  logic               res_last;
  logic               res_error;
  logic [17:0]        accum_x10;
  logic               accept;

  logic               out_valid;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_last;
  logic               out_error;

  assign rx.ready = !out_valid || tx.ready;
  assign accept   = rx.valid && rx.ready;

  assign accum_x10 = 18'(length_accum) * 18'd10 + 18'(rx.rx_byte - CHAR_ZERO);

  always_comb begin
    // a message start restarts the frame before the byte is parsed
    s_phase = rx.msg_start ? PH_PREFIX : phase;
    s_pos   = rx.msg_start ? '0 : prefix_pos;
    s_accum = rx.msg_start ? '0 : length_accum;
    s_chars = rx.msg_start ? '0 : length_chars;
    s_ended = rx.msg_start ? 1'b0 : digits_ended;
    s_left  = rx.msg_start ? '0 : bytes_left;

    phase_next        = s_phase;
    prefix_pos_next   = s_pos;
    length_accum_next = s_accum;
    length_chars_next = s_chars;
    digits_ended_next = s_ended;
    bytes_left_next   = s_left;

    res_valid = 1'b0;
    res_byte  = '0;
    res_last  = 1'b0;
    res_error = 1'b0;

    case (s_phase)
      PH_PREFIX: begin
        if (s_pos < PREFIX_LEN && rx.rx_byte == prefix_byte(s_pos)) begin
          prefix_pos_next = s_pos + 1'b1;
          if (s_pos == PREFIX_LEN - 1'b1) begin
            phase_next = PH_SEP;
          end
        end else begin
          phase_next = PH_IGNORE;
        end
      end
      PH_SEP: begin
        phase_next = PH_LENGTH;
      end
      PH_LENGTH: begin
        if (rx.rx_byte == CHAR_COLON) begin
          if (s_accum == '0) begin
            phase_next = PH_IGNORE;
          end else begin
            bytes_left_next = s_accum;
            phase_next      = PH_PAYLOAD;
          end
        end else begin
          length_chars_next = s_chars + 1'b1;
          if (s_chars + 1'b1 > CHARS_LIMIT) begin
            phase_next = PH_IGNORE;
            res_valid  = 1'b1;
            res_error  = 1'b1;
          end else if (!s_ended && rx.rx_byte >= CHAR_ZERO && rx.rx_byte <= CHAR_NINE) begin
            // start never coincides with length phase, so s_accum == length_accum
            length_accum_next = (accum_x10 > 18'(LEN_SAT)) ? LEN_SAT : accum_x10[LEN_W-1:0];
          end else begin
            digits_ended_next = 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid       = 1'b1;
        res_byte        = rx.rx_byte;
        res_last        = (s_left == LEN_W'(1));
        bytes_left_next = s_left - 1'b1;
        if (s_left == LEN_W'(1)) begin
          phase_next = PH_IGNORE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      prefix_pos   <= '0;
      length_accum <= '0;
      length_chars <= '0;
      digits_ended <= 1'b0;
      bytes_left   <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      prefix_pos   <= prefix_pos_next;
      length_accum <= length_accum_next;
      length_chars <= length_chars_next;
      digits_ended <= digits_ended_next;
      bytes_left   <= bytes_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte  <= res_byte;
      out_last  <= res_last;
      out_error <= res_error;
    end
  end

  assign tx.valid        = out_valid;
  assign tx.payload_byte = out_byte;
  assign tx.last_byte    = out_last;
  assign tx.frame_error  = out_error;

  a_payload_has_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> bytes_left != '0)
    else $error("payload phase with no bytes left");

  a_length_chars_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LENGTH |-> length_chars <= CHARS_LIMIT)
    else $error("length text count past limit while parsing length");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !rx.ready |=> $stable(phase) && $stable(bytes_left))
    else $error("parser state moved while input was blocked");

  a_error_item_clean: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.frame_error |-> tx.payload_byte == '0 && !tx.last_byte)
    else $error("error item carries payload data");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    accept && phase_next == PH_PAYLOAD && s_phase == PH_PAYLOAD |-> !res_last)
    else $error("last byte flagged while frame continues");

endmodule
